FILE: rtl/rbc_pkg.sv
// types and codes shared by the reorder buffer commit block
`timescale 1ns / 1ps
package rbc_pkg;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] mop_tag;
    logic [1:0] uop_class;
    logic       mop_begin;
    logic       mop_end_in;
    logic [5:0] entry_index;
    logic       store_ready;
  } in_word_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic       accepted;
    logic [5:0] slot_index;
    logic [7:0] tag_out;
    logic [1:0] class_out;
    logic       mop_retired;
    logic [2:0] stall_code;
    logic [6:0] occupancy;
    logic       last_result;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CPL_WR, S_TICK, S_TLOOP, S_TWAIT, S_SQ, S_SQWAIT, S_FINAL
  } state_t;

  localparam logic [2:0] K_INSERT   = 3'd0;
  localparam logic [2:0] K_COMPLETE = 3'd1;
  localparam logic [2:0] K_TICK     = 3'd2;
  localparam logic [2:0] K_RECOVER  = 3'd3;
  localparam logic [2:0] K_FLUSH    = 3'd4;

  localparam logic [2:0] R_INSERT = 3'd0;
  localparam logic [2:0] R_RETIRE = 3'd1;
  localparam logic [2:0] R_NORET  = 3'd2;
  localparam logic [2:0] R_SQUASH = 3'd3;
  localparam logic [2:0] R_ACK    = 3'd4;

  localparam logic [2:0] SR_NONE     = 3'd0;
  localparam logic [2:0] SR_NOTREADY = 3'd1;
  localparam logic [2:0] SR_PARTIAL  = 3'd2;
  localparam logic [2:0] SR_EMPTY    = 3'd3;
  localparam logic [2:0] SR_DEADLOCK = 3'd4;

  localparam logic [1:0] CFG_WIDTH = 2'd0;
  localparam logic [1:0] CFG_SIZE  = 2'd1;
  localparam logic [1:0] CFG_LIMIT = 2'd2;

  localparam logic [1:0] CLS_STD = 2'd3;

endpackage

FILE: rtl/rbc_ram.sv
// entry memory with one write port and one registered read port
`timescale 1ns / 1ps
module rbc_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 13
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end
endmodule

FILE: rtl/reorder_buffer_commit.sv
// reorder buffer with in-order retire, top level
// insert and unused codes answer from idle; complete reads the entry and writes it back
// tick: watchdog check, then head checks; a no-retire word after retires goes via S_FINAL
// recover and flush squash uops from the tail back until a kept uop (recover) or empty
// results are one-cycle strobes; the receiver cannot stall
// synchronous reset clears pointers, count and watchdog, presets config; entries undefined
`timescale 1ns / 1ps
module reorder_buffer_commit #(
  parameter int ROB_DEPTH = 64,
  parameter int MAX_WIDTH = 8,
  parameter int TAG_BITS  = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rbc_pkg::in_word_t cmd,
  output logic              result_valid,
  output rbc_pkg::out_word_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [23:0]       cfg_data
);
  import rbc_pkg::*;

  localparam int PTR_W = $clog2(ROB_DEPTH);
  localparam int CNT_W = $clog2(ROB_DEPTH + 1);
  localparam int EW    = TAG_BITS + 5;
  localparam int CLS_L = TAG_BITS;
  localparam int BEG_B = TAG_BITS + 2;
  localparam int END_B = TAG_BITS + 3;
  localparam int DON_B = TAG_BITS + 4;

  state_t state, state_next;
  logic [PTR_W-1:0] head, head_next, tail, tail_next, scan_p, scan_p_next;
  logic [CNT_W-1:0] count, count_next, i_cnt, i_cnt_next;
  logic [23:0] idle, idle_next, lim, lim_next;
  logic dl_flag, dl_flag_next;
  logic [3:0] cw, cw_next;
  logic [6:0] eiu, eiu_next;
  logic [4:0] n_cnt, n_cnt_next;
  logic [EW-1:0] head_e, head_e_next;
  logic pend_v, pend_v_next, res_v, res_v_next;
  out_word_t pend, pend_next, fin, fin_next, res, res_next;
  in_word_t cmd_r, cmd_r_next;

  logic we, re;
  logic [PTR_W-1:0] wa, ra;
  logic [EW-1:0] wd, rd;

  logic [CNT_W-1:0] sz;
  logic [4:0] wid;
  logic [TAG_BITS-1:0] tag_in, tag_r;
  logic [EW-1:0] he;
  logic [23:0] idle_inc;

  rbc_ram #(.DEPTH(ROB_DEPTH), .WIDTH(EW)) u_ram (
    .clk(clk), .we(we), .wa(wa), .wd(wd), .re(re), .ra(ra), .rd(rd)
  );

  function automatic logic [PTR_W-1:0] inc(logic [PTR_W-1:0] p, logic [CNT_W-1:0] s);
    logic [CNT_W:0] q;
    q = (CNT_W + 1)'(p) + 1'b1;
    return (q >= (CNT_W + 1)'(s)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] dec(logic [PTR_W-1:0] p, logic [CNT_W-1:0] s);
    logic [CNT_W-1:0] m;
    m = s - 1'b1;
    return (p == '0) ? PTR_W'(m) : p - 1'b1;
  endfunction

  function automatic out_word_t mk(logic [2:0] k, logic acc, logic [PTR_W-1:0] slot,
                                   logic [EW-1:0] e, logic ret, logic [2:0] rs,
                                   logic [CNT_W-1:0] occ);
    out_word_t o;
    logic [15:0] s16;
    logic [15:0] t16;
    logic [15:0] o16;
    s16 = 16'(slot);
    t16 = 16'(e[TAG_BITS-1:0]);
    o16 = 16'(occ);
    o.result_kind  = k;
    o.accepted     = acc;
    o.slot_index   = s16[5:0];
    o.tag_out      = t16[7:0];
    o.class_out    = e[CLS_L+1:CLS_L];
    o.mop_retired  = ret;
    o.stall_code   = rs;
    o.occupancy    = o16[6:0];
    o.last_result  = 1'b0;
    return o;
  endfunction

  assign busy         = (state != S_IDLE);
  assign cfg_ready    = 1'b1;
  assign result_valid = res_v;
  assign result       = res;

  always_comb begin
    logic [8:0] e9;
    logic [15:0] t_in;
    logic [15:0] t_r;
    e9 = 9'(eiu);
    if (e9 == 9'd0) begin
      sz = CNT_W'(1);
    end else if (e9 > 9'(ROB_DEPTH)) begin
      sz = CNT_W'(ROB_DEPTH);
    end else begin
      sz = CNT_W'(e9);
    end
    if (cw == 4'd0) begin
      wid = 5'd1;
    end else if (5'(cw) > 5'(MAX_WIDTH)) begin
      wid = 5'(MAX_WIDTH);
    end else begin
      wid = 5'(cw);
    end
    t_in = 16'(cmd.mop_tag);
    t_r = 16'(cmd_r.mop_tag);
    tag_in = t_in[TAG_BITS-1:0];
    tag_r = t_r[TAG_BITS-1:0];
    idle_inc = (idle != 24'hFFFFFF) ? idle + 24'd1 : idle;
    he = (i_cnt == '0) ? rd : head_e;
  end

  always_comb begin
    out_word_t x;
    logic fin_extra;
    logic finish;
    x = '0;
    fin_extra = 1'b0;
    finish = 1'b0;
    state_next = state;
    head_next = head;
    tail_next = tail;
    scan_p_next = scan_p;
    count_next = count;
    i_cnt_next = i_cnt;
    idle_next = idle;
    dl_flag_next = dl_flag;
    cw_next = cw;
    eiu_next = eiu;
    lim_next = lim;
    n_cnt_next = n_cnt;
    head_e_next = head_e;
    pend_v_next = pend_v;
    pend_next = pend;
    fin_next = fin;
    res_v_next = 1'b0;
    res_next = res;
    cmd_r_next = cmd_r;
    we = 1'b0;
    wa = tail;
    wd = '0;
    re = 1'b0;
    ra = scan_p;

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WIDTH: cw_next = cfg_data[3:0];
        CFG_SIZE:  eiu_next = cfg_data[6:0];
        CFG_LIMIT: lim_next = cfg_data;
        default: ;
      endcase
    end

    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd_r_next = cmd;
          pend_v_next = 1'b0;
          priority case (cmd.kind)
            K_INSERT: begin
              res_v_next = 1'b1;
              if (count >= sz) begin
                res_next = mk(R_INSERT, 1'b0, '0, '0, 1'b0, SR_NONE, count);
              end else begin
                we = 1'b1;
                wa = tail;
                wd = {1'b0, cmd.mop_end_in, cmd.mop_begin, cmd.uop_class, tag_in};
                count_next = count + 1'b1;
                tail_next = inc(tail, sz);
                res_next = mk(R_INSERT, 1'b1, tail, wd, 1'b0, SR_NONE, count + 1'b1);
              end
              res_next.last_result = 1'b1;
            end
            K_COMPLETE: begin
              idle_next = '0;
              if (9'(cmd.entry_index) < 9'(ROB_DEPTH)) begin
                re = 1'b1;
                ra = PTR_W'(cmd.entry_index);
                state_next = S_CPL_WR;
              end
              res_v_next = 1'b1;
              res_next = mk(R_ACK, 1'b0, '0, '0, 1'b0, SR_NONE, count);
              res_next.last_result = 1'b1;
            end
            K_TICK: state_next = S_TICK;
            K_RECOVER, K_FLUSH: state_next = S_SQ;
            default: begin
              res_v_next = 1'b1;
              res_next = mk(R_ACK, 1'b0, '0, '0, 1'b0, SR_NONE, count);
              res_next.last_result = 1'b1;
            end
          endcase
        end
      end
      S_CPL_WR: begin
        we = 1'b1;
        wa = PTR_W'(cmd_r.entry_index);
        wd = rd;
        wd[DON_B] = 1'b1;
        state_next = S_IDLE;
      end
      S_TICK: begin
        idle_next = idle_inc;
        if (dl_flag || idle_inc > lim) begin
          dl_flag_next = 1'b1;
          res_v_next = 1'b1;
          res_next = mk(R_NORET, 1'b0, '0, '0, 1'b0, SR_DEADLOCK, count);
          res_next.last_result = 1'b1;
          state_next = S_IDLE;
        end else begin
          n_cnt_next = '0;
          state_next = S_TLOOP;
        end
      end
      S_TLOOP: begin
        if (n_cnt == wid) begin
          finish = 1'b1;
        end else if (count == '0) begin
          finish = 1'b1;
          fin_extra = !pend_v || (n_cnt == '0);
          x = mk(R_NORET, 1'b0, '0, '0, 1'b0, (n_cnt != '0) ? SR_NONE : SR_EMPTY, count);
        end else begin
          re = 1'b1;
          ra = head;
          scan_p_next = head;
          i_cnt_next = '0;
          state_next = S_TWAIT;
        end
      end
      S_TWAIT: begin
        if (i_cnt == '0) begin
          head_e_next = rd;
        end
        if (!rd[DON_B]) begin
          finish = 1'b1;
          fin_extra = 1'b1;
          x = mk(R_NORET, 1'b0, '0, '0, 1'b0,
                 (i_cnt == '0) ? SR_NOTREADY : SR_PARTIAL, count);
        end else if (rd[END_B]) begin
          if (he[CLS_L+1:CLS_L] == CLS_STD && !cmd_r.store_ready) begin
            finish = 1'b1;
            fin_extra = !pend_v;
            x = mk(R_NORET, 1'b0, '0, '0, 1'b0, SR_NONE, count);
          end else begin
            if (pend_v) begin
              res_v_next = 1'b1;
              res_next = pend;
            end
            pend_v_next = 1'b1;
            pend_next = mk(R_RETIRE, 1'b0, head, he, he[END_B], SR_NONE, count - 1'b1);
            count_next = count - 1'b1;
            head_next = inc(head, sz);
            n_cnt_next = n_cnt + 1'b1;
            state_next = S_TLOOP;
          end
        end else if (i_cnt + 1'b1 == count) begin
          finish = 1'b1;
          fin_extra = 1'b1;
          x = mk(R_NORET, 1'b0, '0, '0, 1'b0, SR_PARTIAL, count);
        end else begin
          re = 1'b1;
          ra = inc(scan_p, sz);
          scan_p_next = inc(scan_p, sz);
          i_cnt_next = i_cnt + 1'b1;
        end
      end
      S_SQ: begin
        if (count == '0) begin
          finish = 1'b1;
          fin_extra = !pend_v;
          x = mk(R_ACK, 1'b0, '0, '0, 1'b0, SR_NONE, count);
        end else begin
          re = 1'b1;
          ra = dec(tail, sz);
          scan_p_next = dec(tail, sz);
          state_next = S_SQWAIT;
        end
      end
      S_SQWAIT: begin
        if (cmd_r.kind == K_RECOVER && rd[TAG_BITS-1:0] == tag_r) begin
          finish = 1'b1;
          fin_extra = !pend_v;
          x = mk(R_ACK, 1'b0, '0, '0, 1'b0, SR_NONE, count);
        end else begin
          if (pend_v) begin
            res_v_next = 1'b1;
            res_next = pend;
          end
          pend_v_next = 1'b1;
          pend_next = mk(R_SQUASH, 1'b0, scan_p, rd, 1'b0, SR_NONE, count - 1'b1);
          tail_next = scan_p;
          count_next = count - 1'b1;
          state_next = S_SQ;
        end
      end
      S_FINAL: begin
        res_v_next = 1'b1;
        res_next = fin;
        res_next.last_result = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase

    if (finish) begin
      pend_v_next = 1'b0;
      res_v_next = 1'b1;
      if (pend_v) begin
        res_next = pend;
        res_next.last_result = !fin_extra;
        fin_next = x;
        state_next = fin_extra ? S_FINAL : S_IDLE;
      end else begin
        res_next = x;
        res_next.last_result = 1'b1;
        state_next = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      tail    <= '0;
      count   <= '0;
      idle    <= '0;
      dl_flag <= 1'b0;
      cw      <= 4'd4;
      eiu     <= 7'd64;
      lim     <= 24'd500000;
      pend_v  <= 1'b0;
      res_v   <= 1'b0;
    end else begin
      state   <= state_next;
      head    <= head_next;
      tail    <= tail_next;
      count   <= count_next;
      idle    <= idle_next;
      dl_flag <= dl_flag_next;
      cw      <= cw_next;
      eiu     <= eiu_next;
      lim     <= lim_next;
      pend_v  <= pend_v_next;
      res_v   <= res_v_next;
    end
    scan_p <= scan_p_next;
    i_cnt  <= i_cnt_next;
    n_cnt  <= n_cnt_next;
    head_e <= head_e_next;
    pend   <= pend_next;
    fin    <= fin_next;
    res    <= res_next;
    cmd_r  <= cmd_r_next;
  end
endmodule

FILE: tb/testbench.sv
// self-checking testbench for the reorder buffer commit block
`timescale 1ns / 1ps
module testbench;
  import rbc_pkg::*;

  localparam int DEPTH = 64;
  localparam int WMAX = 8;
  localparam int IDLE_MAX = 24'hFFFFFF;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  in_word_t cmd;
  logic result_valid;
  out_word_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [23:0] cfg_data;

  reorder_buffer_commit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .result_valid(result_valid), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow buffer state
  logic [7:0] rob_tag [DEPTH];
  logic [1:0] rob_cls [DEPTH];
  logic rob_end [DEPTH];
  logic rob_done [DEPTH];
  logic rob_written [DEPTH];
  int hd, tl, held, idle_cnt;
  logic dl_flag;
  logic [3:0] cfg_width;
  logic [6:0] cfg_size;
  logic [23:0] cfg_limit;

  out_word_t pending_results[$];
  int errors;
  int sender_idle_pct;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int ring_size();
    int n;
    n = cfg_size;
    if (n < 1) n = 1;
    if (n > DEPTH) n = DEPTH;
    return n;
  endfunction

  function automatic int next_slot(int p);
    return (p + 1 >= ring_size()) ? 0 : p + 1;
  endfunction

  function automatic int prev_slot(int p);
    return (p == 0) ? ring_size() - 1 : p - 1;
  endfunction

  function automatic out_word_t make_word(logic [2:0] rk, logic acc, int slot, logic [7:0] tg,
                                          logic [1:0] cl, logic ret, logic [2:0] why);
    out_word_t o;
    o.result_kind = rk;
    o.accepted = acc;
    o.slot_index = slot[5:0];
    o.tag_out = tg;
    o.class_out = cl;
    o.mop_retired = ret;
    o.stall_code = why;
    o.occupancy = held[6:0];
    o.last_result = 1'b0;
    return o;
  endfunction

  function automatic logic [2:0] head_check();
    int p;
    p = hd;
    for (int i = 0; i < held; i++) begin
      if (!rob_done[p]) return (i == 0) ? SR_NOTREADY : SR_PARTIAL;
      if (rob_end[p]) return SR_NONE;
      p = next_slot(p);
    end
    return SR_PARTIAL;
  endfunction

  task automatic predict_results(in_word_t w);
    out_word_t r[$];
    int width;
    int slot;
    logic [2:0] why;
    logic [2:0] st;
    bit all;
    why = SR_NONE;
    case (w.kind)
      K_INSERT: begin
        if (held >= ring_size()) begin
          r.push_back(make_word(R_INSERT, 1'b0, 0, 8'd0, 2'd0, 1'b0, SR_NONE));
        end else begin
          slot = tl;
          rob_tag[slot] = w.mop_tag;
          rob_cls[slot] = w.uop_class;
          rob_end[slot] = w.mop_end_in;
          rob_done[slot] = 1'b0;
          rob_written[slot] = 1'b1;
          held++;
          tl = next_slot(tl);
          r.push_back(make_word(R_INSERT, 1'b1, slot, w.mop_tag, w.uop_class, 1'b0, SR_NONE));
        end
      end
      K_COMPLETE: begin
        rob_done[w.entry_index] = 1'b1;
        idle_cnt = 0;
        r.push_back(make_word(R_ACK, 1'b0, 0, 8'd0, 2'd0, 1'b0, SR_NONE));
      end
      K_TICK: begin
        if (idle_cnt < IDLE_MAX) idle_cnt++;
        if (idle_cnt > cfg_limit) dl_flag = 1'b1;
        if (dl_flag) begin
          r.push_back(make_word(R_NORET, 1'b0, 0, 8'd0, 2'd0, 1'b0, SR_DEADLOCK));
        end else begin
          width = cfg_width;
          if (width < 1) width = 1;
          if (width > WMAX) width = WMAX;
          for (int n = 0; n < width; n++) begin
            if (held == 0) begin
              why = (n != 0) ? SR_NONE : SR_EMPTY;
              break;
            end
            st = head_check();
            if (st != SR_NONE) begin
              why = st;
              break;
            end
            slot = hd;
            if (rob_cls[slot] == CLS_STD && !w.store_ready) break;
            held--;
            hd = next_slot(hd);
            r.push_back(make_word(R_RETIRE, 1'b0, slot, rob_tag[slot], rob_cls[slot],
                                  rob_end[slot], SR_NONE));
          end
          if (r.size() == 0 || why != SR_NONE)
            r.push_back(make_word(R_NORET, 1'b0, 0, 8'd0, 2'd0, 1'b0, why));
        end
      end
      K_RECOVER, K_FLUSH: begin
        all = (w.kind == K_FLUSH);
        while (held > 0) begin
          slot = prev_slot(tl);
          if (!all && rob_tag[slot] == w.mop_tag) break;
          tl = slot;
          held--;
          r.push_back(make_word(R_SQUASH, 1'b0, slot, rob_tag[slot], rob_cls[slot], 1'b0,
                                SR_NONE));
        end
        if (r.size() == 0) r.push_back(make_word(R_ACK, 1'b0, 0, 8'd0, 2'd0, 1'b0, SR_NONE));
      end
      default: r.push_back(make_word(R_ACK, 1'b0, 0, 8'd0, 2'd0, 1'b0, SR_NONE));
    endcase
    r[r.size() - 1].last_result = 1'b1;
    foreach (r[i]) pending_results.push_back(r[i]);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && result_valid) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %p", result);
      end else begin
        want = pending_results.pop_front();
        if (result !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p got %p", want, result);
        end
      end
    end
  end

  task automatic issue_cmd(in_word_t w);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < sender_idle_pct) gap = $urandom_range(1, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= w;
    forever begin
      @(negedge clk);
      if (!busy) break;
      @(posedge clk);
    end
    predict_results(w);
    @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
      @(posedge clk);
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_WIDTH: cfg_width = data[3:0];
      CFG_SIZE: cfg_size = data[6:0];
      CFG_LIMIT: cfg_limit = data;
      default: ;
    endcase
  endtask

  function automatic in_word_t word_of(logic [2:0] k, logic [7:0] tg, logic [1:0] cl,
                                      logic b, logic e, logic [5:0] ix, logic sr);
    in_word_t w;
    w.kind = k;
    w.mop_tag = tg;
    w.uop_class = cl;
    w.mop_begin = b;
    w.mop_end_in = e;
    w.entry_index = ix;
    w.store_ready = sr;
    return w;
  endfunction

  function automatic int held_slot(int off);
    int p;
    p = hd;
    for (int i = 0; i < off; i++) p = next_slot(p);
    return p;
  endfunction

  task automatic test_directed();
    issue_cmd(word_of(K_TICK, 8'h00, 2'd0, 1'b0, 1'b0, 6'd0, 1'b1));
    issue_cmd(word_of(K_INSERT, 8'h00, 2'd0, 1'b1, 1'b0, 6'd0, 1'b0));
    issue_cmd(word_of(K_INSERT, 8'h00, CLS_STD, 1'b0, 1'b1, 6'd0, 1'b0));
    issue_cmd(word_of(K_TICK, 8'h00, 2'd0, 1'b0, 1'b0, 6'd0, 1'b1));
    issue_cmd(word_of(K_COMPLETE, 8'h00, 2'd0, 1'b0, 1'b0, 6'd0, 1'b0));
    issue_cmd(word_of(K_TICK, 8'h00, 2'd0, 1'b0, 1'b0, 6'd0, 1'b1));
    issue_cmd(word_of(K_COMPLETE, 8'h00, 2'd0, 1'b0, 1'b0, 6'd1, 1'b0));
    issue_cmd(word_of(K_TICK, 8'h00, 2'd0, 1'b0, 1'b0, 6'd0, 1'b0));
    issue_cmd(word_of(K_TICK, 8'h00, 2'd0, 1'b0, 1'b0, 6'd0, 1'b1));
    issue_cmd(word_of(K_INSERT, 8'hFF, 2'd1, 1'b1, 1'b1, 6'd0, 1'b0));
    issue_cmd(word_of(K_INSERT, 8'h5A, 2'd2, 1'b1, 1'b0, 6'd0, 1'b0));
    issue_cmd(word_of(K_COMPLETE, 8'h00, 2'd0, 1'b0, 1'b0, 6'd2, 1'b0));
    issue_cmd(word_of(K_COMPLETE, 8'h00, 2'd0, 1'b0, 1'b0, 6'd3, 1'b0));
    issue_cmd(word_of(K_TICK, 8'h00, 2'd0, 1'b0, 1'b0, 6'd0, 1'b1));
    issue_cmd(word_of(K_RECOVER, 8'h5A, 2'd0, 1'b0, 1'b0, 6'd0, 1'b0));
    issue_cmd(word_of(K_INSERT, 8'h33, CLS_STD, 1'b1, 1'b1, 6'd0, 1'b0));
    issue_cmd(word_of(K_RECOVER, 8'h5A, 2'd0, 1'b0, 1'b0, 6'd0, 1'b0));
    issue_cmd(word_of(K_RECOVER, 8'h77, 2'd0, 1'b0, 1'b0, 6'd0, 1'b0));
    issue_cmd(word_of(K_INSERT, 8'h12, 2'd1, 1'b1, 1'b0, 6'd0, 1'b0));
    issue_cmd(word_of(K_INSERT, 8'h12, 2'd0, 1'b0, 1'b1, 6'd0, 1'b0));
    issue_cmd(word_of(K_FLUSH, 8'h00, 2'd0, 1'b0, 1'b0, 6'd0, 1'b0));
    issue_cmd(word_of(K_FLUSH, 8'h00, 2'd0, 1'b0, 1'b0, 6'd0, 1'b0));
    issue_cmd(word_of(K_COMPLETE, 8'h00, 2'd0, 1'b0, 1'b0, 6'd63, 1'b0));
  endtask

  // every entry gets written once before any resize moves the pointers apart
  task automatic test_fill_entries();
    for (int i = 0; i < DEPTH; i++)
      issue_cmd(word_of(K_INSERT, 8'(i), 2'(i), 1'b1, 1'b1, 6'd0, 1'b0));
    issue_cmd(word_of(K_FLUSH, 8'h00, 2'd0, 1'b0, 1'b0, 6'd0, 1'b0));
  endtask

  task automatic test_full_buffer();
    write_reg(CFG_SIZE, 24'd0);
    issue_cmd(word_of(K_INSERT, 8'hA1, 2'd1, 1'b1, 1'b1, 6'd0, 1'b0));
    issue_cmd(word_of(K_INSERT, 8'hA2, 2'd2, 1'b1, 1'b1, 6'd0, 1'b0));
    issue_cmd(word_of(K_FLUSH, 8'h00, 2'd0, 1'b0, 1'b0, 6'd0, 1'b0));
    write_reg(CFG_SIZE, 24'd3);
    repeat (4) issue_cmd(word_of(K_INSERT, 8'($urandom), 2'($urandom), 1'b1, 1'b1, 6'd0,
                                  1'b0));
    issue_cmd(word_of(K_FLUSH, 8'h00, 2'd0, 1'b0, 1'b0, 6'd0, 1'b0));
    write_reg(CFG_SIZE, 24'd127);
  endtask

  task automatic random_traffic(int n_items);
    int sent;
    int r;
    int len;
    int off;
    logic [7:0] tg;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        len = $urandom_range(1, 3);
        tg = $urandom;
        for (int i = 0; i < len; i++) begin
          issue_cmd(word_of(K_INSERT, tg, 2'($urandom), i == 0,
                            (i == len - 1) && ($urandom_range(0, 9) != 0), 6'($urandom),
                            1'($urandom)));
          sent++;
        end
      end else if (r < 60) begin
        off = (held > 0 && $urandom_range(0, 99) < 85) ?
              held_slot($urandom_range(0, held - 1)) : $urandom_range(0, DEPTH - 1);
        issue_cmd(word_of(K_COMPLETE, 8'($urandom), 2'($urandom), 1'($urandom),
                          1'($urandom), off[5:0], 1'($urandom)));
        sent++;
      end else if (r < 85) begin
        issue_cmd(word_of(K_TICK, 8'($urandom), 2'($urandom), 1'($urandom), 1'($urandom),
                          6'($urandom), $urandom_range(0, 3) != 0));
        sent++;
      end else if (r < 93) begin
        tg = (held > 0 && $urandom_range(0, 3) != 0) ?
             rob_tag[held_slot($urandom_range(0, held - 1))] : 8'($urandom);
        issue_cmd(word_of(K_RECOVER, tg, 2'($urandom), 1'($urandom), 1'($urandom),
                          6'($urandom), 1'($urandom)));
        sent++;
      end else if (r < 96) begin
        issue_cmd(word_of(K_FLUSH, 8'($urandom), 2'($urandom), 1'($urandom), 1'($urandom),
                          6'($urandom), 1'($urandom)));
        sent++;
      end else begin
        issue_cmd(word_of(K_INSERT, 8'($urandom), 2'($urandom), 1'($urandom), 1'($urandom),
                          6'($urandom), 1'($urandom)));
        sent++;
      end
    end
  endtask

  task automatic test_commit_width();
    sender_idle_pct = 0;
    write_reg(CFG_WIDTH, 24'd0);
    random_traffic(25);
    write_reg(CFG_WIDTH, 24'd15);
    random_traffic(25);
    write_reg(CFG_WIDTH, 24'd8);
    write_reg(CFG_SIZE, 24'd16);
    random_traffic(25);
    write_reg(CFG_WIDTH, 24'd1);
  endtask

  task automatic test_sender_gaps();
    sender_idle_pct = 84;
    write_reg(CFG_SIZE, 24'd64);
    random_traffic(45);
    sender_idle_pct = 17;
    write_reg(CFG_WIDTH, 24'd4);
    random_traffic(45);
    sender_idle_pct = 0;
    random_traffic(45);
  endtask

  task automatic test_shrink_held();
    bit all_written;
    all_written = 1'b1;
    for (int i = 0; i < DEPTH; i++) if (rob_written[i] !== 1'b1) all_written = 1'b0;
    if (!all_written) issue_cmd(word_of(K_FLUSH, 8'h00, 2'd0, 1'b0, 1'b0, 6'd0, 1'b0));
    issue_cmd(word_of(K_INSERT, 8'h41, 2'd0, 1'b1, 1'b1, 6'd0, 1'b0));
    issue_cmd(word_of(K_INSERT, 8'h42, 2'd0, 1'b1, 1'b1, 6'd0, 1'b0));
    write_reg(CFG_SIZE, 24'd8);
    random_traffic(30);
    write_reg(CFG_SIZE, 24'd64);
    issue_cmd(word_of(K_FLUSH, 8'h00, 2'd0, 1'b0, 1'b0, 6'd0, 1'b0));
  endtask

  task automatic test_watchdog();
    write_reg(CFG_LIMIT, 24'hFFFFFF);
    random_traffic(20);
    write_reg(CFG_LIMIT, 24'd3);
    issue_cmd(word_of(K_COMPLETE, 8'h00, 2'd0, 1'b0, 1'b0, 6'd5, 1'b0));
    repeat (2) issue_cmd(word_of(K_TICK, 8'h00, 2'd0, 1'b0, 1'b0, 6'd0, 1'b1));
    issue_cmd(word_of(K_COMPLETE, 8'h00, 2'd0, 1'b0, 1'b0, 6'd6, 1'b0));
    write_reg(CFG_LIMIT, 24'd1);
    repeat (3) issue_cmd(word_of(K_TICK, 8'h00, 2'd0, 1'b0, 1'b0, 6'd0, 1'b1));
    issue_cmd(word_of(K_INSERT, 8'h99, 2'd1, 1'b1, 1'b1, 6'd0, 1'b0));
    issue_cmd(word_of(K_COMPLETE, 8'h00, 2'd0, 1'b0, 1'b0, 6'(tl == 0 ? 63 : tl - 1), 1'b0));
    repeat (2) issue_cmd(word_of(K_TICK, 8'h00, 2'd0, 1'b0, 1'b0, 6'd0, 1'b1));
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    cmd <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    errors = 0;
    sender_idle_pct = 0;
    hd = 0;
    tl = 0;
    held = 0;
    idle_cnt = 0;
    dl_flag = 1'b0;
    cfg_width = 4'd4;
    cfg_size = 7'd64;
    cfg_limit = 24'd500000;
    for (int i = 0; i < DEPTH; i++) begin
      rob_written[i] = 1'b0;
      rob_done[i] = 1'b0;
      rob_end[i] = 1'b0;
      rob_tag[i] = '0;
      rob_cls[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fill_entries();
    test_full_buffer();
    test_commit_width();
    test_sender_gaps();
    test_shrink_held();
    test_watchdog();
    settle();
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
